@@ design/cla_pkg.sv @@
`timescale 1ns / 1ps

package cla_pkg;

    localparam int STORE_BYTES_DEF = 64;
    localparam int CHAR_W          = 8;
    localparam int TICK_W          = 16;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [CHAR_W-1:0] CH_HT    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        S_ACCEPT,
        S_READ,
        S_LOAD,
        S_EMPTY
    } t_state;

    typedef struct packed {
        logic take_item;
        logic rd_issue;
        logic out_load_char;
        logic out_load_empty;
    } t_dp_cmd;

    typedef struct packed {
        logic done_chars;
        logic done_empty;
        logic out_free;
        logic rd_last;
    } t_dp_stat;

endpackage

@@ design/cla_ctrl.sv @@
`timescale 1ns / 1ps

module cla_ctrl import cla_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ACCEPT: begin
                if (i_in_valid) begin
                    priority if (i_stat.done_empty) begin
                        n_state = S_EMPTY;
                    end else if (i_stat.done_chars) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_ACCEPT;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.rd_last ? S_ACCEPT : S_READ;
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    n_state = S_ACCEPT;
                end
            end
            default: n_state = S_ACCEPT;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_ACCEPT: begin
                o_in_stall      = 1'b0;
                o_cmd.take_item = i_in_valid;
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
            end
            S_LOAD: begin
                o_cmd.out_load_char = i_stat.out_free;
            end
            S_EMPTY: begin
                o_cmd.out_load_empty = i_stat.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    a_empty_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_item && i_stat.done_empty |=> r_state == S_EMPTY)
        else $error("empty completion did not enter empty state");

    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_issue |=> r_state == S_LOAD)
        else $error("read not followed by load");

    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load_char && i_stat.rd_last |=> r_state == S_ACCEPT)
        else $error("last character did not end drain");

endmodule

@@ design/cla_dp.sv @@
`timescale 1ns / 1ps

module cla_dp import cla_pkg::*; #(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_data,
    input  logic              i_op,
    input  logic [CHAR_W-1:0] i_rx_byte,
    input  logic              i_out_stall,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output logic              o_out_valid,
    output logic [CHAR_W-1:0] o_msg_char,
    output logic              o_last_char,
    output logic              o_empty_message
);

    localparam int CNT_W = $clog2(STORE_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(STORE_BYTES - 1);

    logic [CHAR_W-1:0] r_mem [STORE_BYTES];
    logic [CHAR_W-1:0] r_rd_data;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_rd_idx;
    logic [TICK_W-1:0] r_ticks;
    logic [TICK_W-1:0] n_ticks;
    logic [TICK_W-1:0] r_timeout;
    logic              r_last_space;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;
    logic              r_out_empty;

    logic [CHAR_W-1:0] c_eff;
    logic              is_byte;
    logic              is_term;
    logic              drop_space;
    logic              is_open;
    logic [CNT_W-1:0]  base_count;
    logic              do_store;
    logic              rd_last;
    logic              out_free;

    always_comb begin
        is_byte    = i_op == OP_BYTE;
        is_term    = (i_rx_byte == CH_CR) || (i_rx_byte == CH_SEMI);
        c_eff      = ((i_rx_byte == CH_HT) || (i_rx_byte == CH_LF)) ? CH_SPACE : i_rx_byte;
        drop_space = (c_eff == CH_SPACE) && ((r_count == '0) || r_last_space);
        is_open    = c_eff == CH_OPEN;
        base_count = is_open ? '0 : r_count;
        do_store   = is_byte && !is_term && !drop_space && (base_count < CNT_MAX);
        rd_last    = (r_rd_idx + CNT_W'(1)) == r_count;
        out_free   = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        o_stat.done_chars = is_byte && ((is_term && (r_count != '0))
                                        || (do_store && (c_eff == CH_CLOSE)));
        o_stat.done_empty = is_byte && is_term && (r_count == '0);
        o_stat.out_free   = out_free;
        o_stat.rd_last    = rd_last;
    end

    always_comb begin
        n_ticks = r_ticks;
        n_count = r_count;
        if (i_cmd.take_item) begin
            if (is_byte) begin
                n_ticks = '0;
                if (do_store) begin
                    n_count = base_count + CNT_W'(1);
                end
            end else begin
                n_ticks = (r_ticks == '1) ? r_ticks : r_ticks + TICK_W'(1);
                if ((r_count != '0) && (n_ticks >= r_timeout)) begin
                    n_count = '0;
                end
            end
        end else if (i_cmd.out_load_char && rd_last) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_ticks      <= '0;
            r_timeout    <= TIMEOUT_RESET;
            r_last_space <= 1'b0;
            r_out_valid  <= 1'b0;
            r_rd_idx     <= '0;
        end else begin
            r_count <= n_count;
            r_ticks <= n_ticks;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (i_cmd.take_item && do_store) begin
                r_last_space <= c_eff == CH_SPACE;
            end
            if (i_cmd.take_item) begin
                r_rd_idx <= '0;
            end else if (i_cmd.out_load_char) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            if (i_cmd.out_load_char || i_cmd.out_load_empty) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item && do_store) begin
            r_mem[base_count] <= c_eff;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_char) begin
            r_out_char  <= r_rd_data;
            r_out_last  <= rd_last;
            r_out_empty <= 1'b0;
        end else if (i_cmd.out_load_empty) begin
            r_out_char  <= '0;
            r_out_last  <= 1'b1;
            r_out_empty <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_msg_char      = r_out_char;
    assign o_last_char     = r_out_last;
    assign o_empty_message = r_out_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("stored count beyond capacity");

    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load_empty |=> o_out_valid && o_last_char && (o_msg_char == '0))
        else $error("empty result malformed");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load_char && rd_last |=> r_count == '0)
        else $error("store not cleared after drain");

endmodule

@@ design/command_line_assembler_unit.sv @@
`timescale 1ns / 1ps
// A byte or tick is taken while the unit is idle; the input stalls while a message drains or an empty result waits.
// A completed message is drained one character at a time: each character is first read from the
// store into a register (read state), then loaded into the output once it is free (load state).
// An empty message gives its single result, loaded into the output once it is free.
// Reset (synchronous, active low) clears count, tick counter and output valid, and sets
// the timeout to 1000; character store contents are left as they are.

module command_line_assembler_unit import cla_pkg::*; #(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_op,
    input  logic [CHAR_W-1:0] i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CHAR_W-1:0] o_msg_char,
    output logic              o_last_char,
    output logic              o_empty_message
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    cla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    cla_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_rx_byte       (i_rx_byte),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_msg_char      (o_msg_char),
        .o_last_char     (o_last_char),
        .o_empty_message (o_empty_message)
    );

endmodule
